### hw/rtl/psafl_pkg.sv
// Shared types, codes and defaults for the per-source failure limiter
`timescale 1ns / 1ps
`default_nettype none

package psafl_pkg;

  // table size default
  localparam int DEFAULT_TABLE_ENTRIES = 32;

  // operation codes
  localparam logic [1:0] OP_RECORD  = 2'd0;
  localparam logic [1:0] OP_QUERY   = 2'd1;
  localparam logic [1:0] OP_CLEANUP = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_IDX_WINDOW    = 2'd0;
  localparam logic [1:0] CFG_IDX_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_IDX_COOLDOWN  = 2'd2;

  // configuration reset values
  localparam logic [15:0] WINDOW_RESET    = 16'd60;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd5;
  localparam logic [15:0] COOLDOWN_RESET  = 16'd300;

  // freed counter saturation
  localparam logic [5:0] FREED_MAX = 6'd63;

  // configuration seen by every cell
  typedef struct packed {
    logic [15:0] win;
    logic [7:0]  thr;
    logic [15:0] cd;
  } psafl_cfg_t;

  // operation token handed from cell to cell
  typedef struct packed {
    logic        vld;
    logic [1:0]  op;
    logic        alloc;
    logic        fam;
    logic [63:0] kh;
    logic [63:0] kl;
    logic [31:0] now;
    logic        done;
    logic        blocked;
    logic        throttled;
    logic [5:0]  freed;
  } psafl_tok_t;

  // result fields of one item
  typedef struct packed {
    logic       blocked;
    logic       throttled;
    logic       full;
    logic [5:0] freed;
  } psafl_res_t;

endpackage

`default_nettype wire

### hw/rtl/psafl_cell.sv
// One table entry of the limiter: holds a source record and updates it as the token passes
`timescale 1ns / 1ps
`default_nettype none

module psafl_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  psafl_pkg::psafl_cfg_t cfg_i,
  input  psafl_pkg::psafl_tok_t tok_i,
  output psafl_pkg::psafl_tok_t tok_o
);
  import psafl_pkg::*;

  // entry state
  logic        valid_r, valid_nxt;
  logic        fam_r, fam_nxt;
  logic [63:0] kh_r, kh_nxt;
  logic [63:0] kl_r, kl_nxt;
  logic [31:0] ws_r, ws_nxt;
  logic [7:0]  f_r, f_nxt;
  logic [31:0] bu_r, bu_nxt;
  psafl_tok_t  tok_r, tok_nxt;

  logic        hit, claim, upd, active_b, blk, thr_hit, freeable;
  logic [31:0] ws_b, elapsed;
  logic [7:0]  f_b;
  logic [8:0]  cnt;

  // match, window and block tests
  always_comb begin
    hit      = valid_r && (fam_r == tok_i.fam) && (kh_r == tok_i.kh) && (kl_r == tok_i.kl);
    claim    = (tok_i.op == OP_RECORD) && tok_i.alloc && !tok_i.done && !valid_r;
    upd      = (tok_i.op == OP_RECORD) && !tok_i.alloc && hit;
    ws_b     = claim ? 32'd0 : ws_r;
    f_b      = claim ? 8'd0 : f_r;
    elapsed  = tok_i.now - ws_b;
    active_b = (ws_b != 32'd0) && (elapsed <= {16'd0, cfg_i.win});
    cnt      = (active_b ? {1'b0, f_b} : 9'd0) + 9'd1;
    thr_hit  = cnt >= {1'b0, cfg_i.thr};
    blk      = bu_r > tok_i.now;
    freeable = (tok_i.op == OP_CLEANUP) && valid_r && !blk && !active_b;
  end

  // entry update and token pass-on
  always_comb begin
    valid_nxt = valid_r;
    fam_nxt   = fam_r;
    kh_nxt    = kh_r;
    kl_nxt    = kl_r;
    ws_nxt    = ws_r;
    f_nxt     = f_r;
    bu_nxt    = bu_r;
    tok_nxt   = tok_i;
    if (tok_i.vld) begin
      if (claim) begin
        valid_nxt = 1'b1;
        fam_nxt   = tok_i.fam;
        kh_nxt    = tok_i.kh;
        kl_nxt    = tok_i.kl;
        bu_nxt    = 32'd0;
      end
      if (claim || upd) begin
        tok_nxt.done = 1'b1;
        if (thr_hit) begin
          bu_nxt            = tok_i.now + {16'd0, cfg_i.cd};
          f_nxt             = 8'd0;
          ws_nxt            = 32'd0;
          tok_nxt.throttled = 1'b1;
        end else begin
          f_nxt  = cnt[7:0];
          ws_nxt = active_b ? ws_b : tok_i.now;
        end
      end
      if ((tok_i.op == OP_QUERY) && hit && blk) begin
        tok_nxt.blocked = 1'b1;
      end
      if (freeable) begin
        valid_nxt = 1'b0;
        if (tok_i.freed != FREED_MAX) begin
          tok_nxt.freed = tok_i.freed + 6'd1;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fam_r <= fam_nxt;
    kh_r  <= kh_nxt;
    kl_r  <= kl_nxt;
    ws_r  <= ws_nxt;
    f_r   <= f_nxt;
    bu_r  <= bu_nxt;
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

### hw/rtl/per_source_auth_failure_limiter.sv
// Top level of the per-source authentication failure limiter
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_tvalid/tready   | tuser: op, family; tdata: addr_high, addr_low, now
//  out_    | output    | out_tvalid/tready  | tdata: blocked, throttled_now, table_full, freed_count
//  cfg_    | input     | cfg_valid/ready    | cfg_index, cfg_data
//
// An item's token walks the row of entry cells, one cell per cycle. A record for an unseen
// source takes a second pass to claim the lowest free entry; other items take one pass.
// Synchronous active-low reset empties the table and restores the register defaults.
// A result waits in the output register while the next item is taken; a second finished
// result is held until the first transfer completes. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module per_source_auth_failure_limiter #(
  parameter int TABLE_ENTRIES = psafl_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  wire          clk,
  input  wire          rst_n,
  // input stream
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [159:0] in_tdata,  // addr_high[63:0], addr_low[127:64], now[159:128]
  input  wire  [2:0]   in_tuser,  // operation[1:0], is_ipv6[2]
  // result stream
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [15:0]  out_tdata, // blocked[0], throttled_now[1], table_full[2],
                                  // freed_count[8:3], zero[15:9]
  // configuration writes
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [1:0]   cfg_index,
  input  wire  [15:0]  cfg_data
);
  import psafl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t     state_r, state_nxt;
  psafl_cfg_t cfg_r, cfg_nxt;
  psafl_tok_t launch_r, launch_nxt;
  psafl_res_t out_r, out_nxt, pend_r, pend_nxt, res_new;
  logic       out_vld_r, out_vld_nxt;
  psafl_tok_t chain [TABLE_ENTRIES+1];
  psafl_tok_t exit_tok;
  logic       accept, relaunch, finish, out_free, in_fam;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign in_fam    = in_tuser[2];

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_WINDOW:    cfg_nxt.win = cfg_data;
        CFG_IDX_THRESHOLD: cfg_nxt.thr = cfg_data[7:0];
        CFG_IDX_COOLDOWN:  cfg_nxt.cd  = cfg_data;
        default: ;
      endcase
    end
  end

  // row of entry cells
  assign chain[0] = launch_r;
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    psafl_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cfg_i (cfg_r),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end
  assign exit_tok = chain[TABLE_ENTRIES];

  // token exit handling
  always_comb begin
    relaunch = (state_r == ST_RUN) && exit_tok.vld && (exit_tok.op == OP_RECORD) &&
               !exit_tok.alloc && !exit_tok.done;
    finish   = (state_r == ST_RUN) && exit_tok.vld && !relaunch;
    out_free = !out_vld_r || out_tready;
    res_new.blocked   = exit_tok.blocked;
    res_new.throttled = exit_tok.throttled;
    res_new.full      = (exit_tok.op == OP_RECORD) && !exit_tok.done;
    res_new.freed     = exit_tok.freed;
  end

  // launch token
  always_comb begin
    launch_nxt     = launch_r;
    launch_nxt.vld = 1'b0;
    if (accept) begin
      launch_nxt.vld       = 1'b1;
      launch_nxt.op        = in_tuser[1:0];
      launch_nxt.alloc     = 1'b0;
      launch_nxt.fam       = in_fam;
      launch_nxt.kh        = in_fam ? in_tdata[63:0] : 64'd0;
      launch_nxt.kl        = in_fam ? in_tdata[127:64] : {32'd0, in_tdata[95:64]};
      launch_nxt.now       = in_tdata[159:128];
      launch_nxt.done      = 1'b0;
      launch_nxt.blocked   = 1'b0;
      launch_nxt.throttled = 1'b0;
      launch_nxt.freed     = 6'd0;
    end else if (relaunch) begin
      launch_nxt       = exit_tok;
      launch_nxt.alloc = 1'b1;
    end
  end

  // sequencer and output register
  always_comb begin
    state_nxt   = state_r;
    out_nxt     = out_r;
    pend_nxt    = pend_r;
    out_vld_nxt = out_vld_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          if (out_free) begin
            out_nxt     = res_new;
            out_vld_nxt = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            pend_nxt  = res_new;
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_nxt     = pend_r;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      cfg_r     <= '{win: WINDOW_RESET, thr: THRESHOLD_RESET, cd: COOLDOWN_RESET};
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      cfg_r     <= cfg_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
    if (!rst_n) begin
      launch_r <= '0;
    end else begin
      launch_r <= launch_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_r.freed, out_r.full, out_r.throttled, out_r.blocked};

endmodule

`default_nettype wire

### verif/tb_per_source_auth_failure_limiter.sv
// Self-checking testbench for the per-source authentication failure limiter
`timescale 1ns / 1ps

module tb_per_source_auth_failure_limiter;
  import psafl_pkg::*;

  localparam int ENTRIES = DEFAULT_TABLE_ENTRIES;
  // operation code the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // register index that maps to no register
  localparam logic [1:0] CFG_IDX_SPARE = 2'd3;
  localparam int POOL_N = 24;
  localparam int ITEMS_PER_SETTING = 305;
  // one record for an unseen source takes about two passes over the table
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_CAP = 100;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [159:0] in_tdata   = '0;  // addr_high[63:0], addr_low[127:64], now[159:128]
  logic [2:0]   in_tuser   = '0;  // operation[1:0], is_ipv6[2]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [15:0]  out_tdata;        // blocked[0], throttled_now[1], table_full[2], freed_count[8:3]
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index  = '0;
  logic [15:0]  cfg_data   = '0;

  per_source_auth_failure_limiter #(
    .TABLE_ENTRIES(ENTRIES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // source table shadow and the verdicts it predicts, oldest first
  class limiter_scoreboard;
    logic [15:0] win_s;
    logic [7:0]  thresh;
    logic [15:0] cool_s;
    bit          used     [ENTRIES];
    bit          v6       [ENTRIES];
    logic [63:0] key_hi   [ENTRIES];
    logic [63:0] key_lo   [ENTRIES];
    logic [31:0] win_start[ENTRIES];
    logic [7:0]  fails    [ENTRIES];
    logic [31:0] blk_until[ENTRIES];
    psafl_res_t  verdicts[$];
    int          mismatches;
    int          accepted;
    int          checked;

    function new();
      win_s  = WINDOW_RESET;
      thresh = THRESHOLD_RESET;
      cool_s = COOLDOWN_RESET;
      foreach (used[i]) used[i] = 1'b0;
      mismatches = 0;
      accepted   = 0;
      checked    = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] value);
      case (idx)
        CFG_IDX_WINDOW:    win_s  = value;
        CFG_IDX_THRESHOLD: thresh = value[7:0];
        CFG_IDX_COOLDOWN:  cool_s = value;
        default: ;
      endcase
    endfunction

    // window counts only when started and not yet lapsed, with wrapping time
    function bit window_open(int i, logic [31:0] now_s);
      logic [31:0] elapsed;
      elapsed = now_s - win_start[i];
      return (win_start[i] != 32'd0) && (elapsed <= {16'd0, win_s});
    endfunction

    function int find_slot(logic fam, logic [63:0] hi, logic [63:0] lo);
      for (int i = 0; i < ENTRIES; i++)
        if (used[i] && v6[i] == fam && key_hi[i] == hi && key_lo[i] == lo) return i;
      return -1;
    endfunction

    function void note_request(logic [1:0] op, logic fam, logic [63:0] hi_in,
                               logic [63:0] lo_in, logic [31:0] now_s);
      psafl_res_t  res;
      logic [63:0] hi;
      logic [63:0] lo;
      int          slot;
      int unsigned count;
      res = '0;
      // an IPv4 key is the low 32 bits only
      hi = fam ? hi_in : 64'd0;
      lo = fam ? lo_in : {32'd0, lo_in[31:0]};
      accepted++;
      case (op)
        OP_RECORD: begin
          slot = find_slot(fam, hi, lo);
          // unseen source claims the lowest free entry
          if (slot < 0) begin
            for (int j = 0; j < ENTRIES; j++) begin
              if (!used[j]) begin
                slot = j;
                break;
              end
            end
            if (slot >= 0) begin
              used[slot]      = 1'b1;
              v6[slot]        = fam;
              key_hi[slot]    = hi;
              key_lo[slot]    = lo;
              win_start[slot] = 32'd0;
              fails[slot]     = 8'd0;
              blk_until[slot] = 32'd0;
            end
          end
          if (slot < 0) begin
            res.full = 1'b1;
          end else begin
            if (!window_open(slot, now_s)) begin
              win_start[slot] = now_s;
              fails[slot]     = 8'd0;
            end
            count = fails[slot] + 1;
            if (count >= thresh) begin
              blk_until[slot] = now_s + {16'd0, cool_s};
              fails[slot]     = 8'd0;
              win_start[slot] = 32'd0;
              res.throttled   = 1'b1;
            end else begin
              fails[slot] = count[7:0];
            end
          end
        end
        OP_QUERY: begin
          slot = find_slot(fam, hi, lo);
          res.blocked = (slot >= 0) && (blk_until[slot] > now_s);
        end
        OP_CLEANUP: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (used[i] && !(blk_until[i] > now_s) && !window_open(i, now_s)) begin
              used[i] = 1'b0;
              if (res.freed != FREED_MAX) res.freed = res.freed + 6'd1;
            end
          end
        end
        default: ;
      endcase
      verdicts.push_back(res);
    endfunction

    task report(string msg);
      if (mismatches < PRINT_CAP) $display("mismatch at %0t result %0d: %s", $time, checked, msg);
      mismatches++;
    endtask

    task check_result(logic [15:0] word);
      psafl_res_t want;
      checked++;
      if (verdicts.size() == 0) begin
        report($sformatf("result %h with nothing pending", word));
        return;
      end
      want = verdicts.pop_front();
      if (word[0] !== want.blocked)
        report($sformatf("blocked %b, want %b", word[0], want.blocked));
      if (word[1] !== want.throttled)
        report($sformatf("throttled_now %b, want %b", word[1], want.throttled));
      if (word[2] !== want.full)
        report($sformatf("table_full %b, want %b", word[2], want.full));
      if (word[8:3] !== want.freed)
        report($sformatf("freed_count %0d, want %0d", word[8:3], want.freed));
      if (word[15:9] !== 7'd0)
        report($sformatf("padding bits %b not zero", word[15:9]));
    endtask
  endclass

  limiter_scoreboard board;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_rx = 1'b0;
  int          cycles = 0;
  logic [31:0] clock_s;
  bit          pool_v6[POOL_N];
  logic [63:0] pool_hi[POOL_N];
  logic [63:0] pool_lo[POOL_N];

  // free-running clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run time limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
    out_tready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  // one long receiver hold-off so the block backs up into its input
  initial begin
    wait (rst_n);
    while (board.accepted < 120) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // offer one item, with random gaps before it, until the transfer
  task automatic drive_item(logic [1:0] op, logic fam, logic [63:0] hi, logic [63:0] lo,
                            logic [31:0] now_s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {fam, op};
    in_tdata  <= {now_s, lo, hi};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(op, fam, hi, lo, now_s);
  endtask

  // pool source; IPv4 items carry junk in the bits that do not count
  task automatic send_pool(logic [1:0] op, int k, logic [31:0] now_s);
    if (pool_v6[k]) drive_item(op, 1'b1, pool_hi[k], pool_lo[k], now_s);
    else drive_item(op, 1'b0, {$urandom, $urandom}, {$urandom, pool_lo[k][31:0]}, now_s);
  endtask

  task automatic send_fresh(logic [1:0] op, logic [31:0] now_s);
    drive_item(op, 1'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom}, now_s);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_register(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.verdicts.size() != 0) @(posedge clk);
  endtask

  // jump long enough for every window and cooldown to lapse
  function automatic int unsigned sweep_span();
    return 2 * board.cool_s + board.win_s + 2;
  endfunction

  task automatic tick_clock(int unsigned span);
    if ($urandom_range(99) < 4) clock_s = clock_s + $urandom_range(span);
    else clock_s = clock_s + $urandom_range(3);
  endtask

  // mostly the running time, now and then zero or anything
  function automatic logic [31:0] stamp();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick == 0) return 32'd0;
    if (pick == 1) return $urandom;
    return clock_s;
  endfunction

  task automatic sweep_later(int unsigned span);
    clock_s = clock_s + span;
    drive_item(OP_CLEANUP, 1'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom},
               clock_s);
  endtask

  // overflow the table with new sources, then free what lapsed
  task automatic flood_table(int unsigned span, inout int sent);
    repeat (ENTRIES + 4) send_fresh(OP_RECORD, clock_s);
    sweep_later(span);
    sent += ENTRIES + 5;
  endtask

  task automatic run_random(int count);
    int          sent;
    int          k;
    int          reps;
    int unsigned pick;
    int unsigned span;
    logic [1:0]  op;
    sent = 0;
    span = sweep_span();
    flood_table(span, sent);
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        // repeated failures of one source, then ask about it
        k    = $urandom_range(POOL_N - 1);
        reps = $urandom_range(1, 8);
        repeat (reps) begin
          tick_clock(span);
          send_pool(OP_RECORD, k, stamp());
        end
        tick_clock(span);
        send_pool(OP_QUERY, k, stamp());
        sent += reps + 1;
      end else if (pick < 93) begin
        // lone item of any kind
        op = (pick < 91) ? 2'($urandom_range(2)) : OP_UNUSED;
        tick_clock(span);
        if ($urandom_range(9) == 0) send_fresh(op, stamp());
        else send_pool(op, $urandom_range(POOL_N - 1), stamp());
        sent++;
      end else if (pick < 99) begin
        sweep_later(span);
        sent++;
      end else begin
        flood_table(span, sent);
      end
    end
  endtask

  task automatic run_directed();
    // unknown source, then a source pushed over the default threshold
    send_pool(OP_QUERY, 0, 32'd100);
    repeat (5) send_pool(OP_RECORD, 0, 32'd100);
    send_pool(OP_QUERY, 0, 32'd101);
    // same low bits under the other family
    send_pool(OP_QUERY, 12, 32'd101);
    // cooldown edges
    send_pool(OP_QUERY, 0, 32'd399);
    send_pool(OP_QUERY, 0, 32'd400);
    // at time zero the window never starts
    repeat (3) send_pool(OP_RECORD, 1, 32'd0);
    // window edge: still open at its length, lapsed one later
    send_pool(OP_RECORD, 2, 32'd1000);
    send_pool(OP_RECORD, 2, 32'd1060);
    send_pool(OP_RECORD, 2, 32'd1061);
    drive_item(OP_UNUSED, 1'b1, '1, '1, '1);
    drive_item(OP_RECORD, 1'b1, '1, '1, '1);
    drive_item(OP_RECORD, 1'b1, '0, '0, '1);
    drive_item(OP_RECORD, 1'b0, '1, '1, 32'h8000_0000);
    drive_item(OP_QUERY, 1'b0, '0, {32'd0, 32'hFFFF_FFFF}, 32'h8000_0000);
    drive_item(OP_CLEANUP, 1'b0, '0, '0, '1);
    drive_item(OP_QUERY, 1'b1, '1, '1, 32'd0);
  endtask

  initial begin
    board = new();
    for (int k = 0; k < POOL_N; k++) begin
      pool_v6[k] = (k >= POOL_N / 2);
      pool_hi[k] = {$urandom, $urandom};
      pool_lo[k] = {$urandom, $urandom};
    end
    // IPv6 twin of IPv4 source 0, and an IPv6 source with a zero high half
    pool_hi[12] = 64'd0;
    pool_lo[12] = {32'd0, pool_lo[0][31:0]};
    pool_hi[13] = 64'd0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 45;
    run_directed();

    wait_idle();
    write_reg(CFG_IDX_WINDOW, 16'd10);
    write_reg(CFG_IDX_THRESHOLD, 16'd3);
    write_reg(CFG_IDX_COOLDOWN, 16'd40);
    clock_s = 32'd5000;
    run_random(ITEMS_PER_SETTING);

    // narrowest window, block on every failure, no cooldown
    wait_idle();
    write_reg(CFG_IDX_WINDOW, 16'd0);
    write_reg(CFG_IDX_THRESHOLD, 16'd1);
    write_reg(CFG_IDX_COOLDOWN, 16'd0);
    run_random(ITEMS_PER_SETTING);

    send_idle_pct = 45;
    recv_idle_pct = 20;
    // widest settings; threshold upper data bits are dropped
    wait_idle();
    write_reg(CFG_IDX_WINDOW, 16'hFFFF);
    write_reg(CFG_IDX_THRESHOLD, 16'h12FF);
    write_reg(CFG_IDX_COOLDOWN, 16'hFFFF);
    run_random(ITEMS_PER_SETTING);

    // threshold of zero, and a write to no register
    wait_idle();
    write_reg(CFG_IDX_WINDOW, 16'd30);
    write_reg(CFG_IDX_THRESHOLD, 16'h0100);
    write_reg(CFG_IDX_COOLDOWN, 16'd500);
    write_reg(CFG_IDX_SPARE, 16'hFFFF);
    run_random(ITEMS_PER_SETTING);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // time runs through the 32-bit wrap
    wait_idle();
    write_reg(CFG_IDX_WINDOW, 16'd200);
    write_reg(CFG_IDX_THRESHOLD, 16'd4);
    write_reg(CFG_IDX_COOLDOWN, 16'd1000);
    write_reg(CFG_IDX_SPARE, 16'h0000);
    clock_s = 32'hFFFF_FC00;
    run_random(ITEMS_PER_SETTING);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### per_source_auth_failure_limiter.f
hw/rtl/psafl_pkg.sv
hw/rtl/psafl_cell.sv
hw/rtl/per_source_auth_failure_limiter.sv
verif/tb_per_source_auth_failure_limiter.sv
